/* src/sort_and_count_inversions_unit_assert.svh */
// Assertion macros shared by the sort and inversion count unit
`ifndef SORT_AND_COUNT_INVERSIONS_UNIT_ASSERT_SVH
`define SORT_AND_COUNT_INVERSIONS_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define SCIC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define SCIC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/scic_pkg.sv */
// Types and constants for the sort and inversion count unit
`timescale 1ns / 1ps

package scic_pkg;

  localparam int unsigned ValW = 32;
  localparam int unsigned InvW = 11;
  localparam logic [InvW-1:0] InvMax = {InvW{1'b1}};

  // Phase of the unit: collecting words or streaming the sorted set out
  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } st_e;

  // Broadcast control for every cell of the chain
  typedef struct packed {
    logic                   ins;  // insert the broadcast word
    logic                   shd;  // shift the chain towards cell 0
    logic signed [ValW-1:0] val;  // word being inserted
  } cell_ctrl_t;

endpackage

/* src/sort_and_count_inversions_unit.sv */
// Top level of the streaming sort unit with inversion count
//
//   channel | direction | handshake               | fields
//   in      | sink      | in_valid_i / in_stall_o   | value_i, last_in_i
//   out     | source    | out_valid_o / out_stall_i | sorted_value_o, inversions_o,
//           |           |                           | dropped_o, last_out_o
//
// Collecting: one word is taken per cycle; every cell compares against it at once.
// Draining: after the last word, the set leaves one word per cycle from cell 0
//   while out_stall_i is low; in_stall_o is high meanwhile.
// Reset clears the valid bits of the chain and the control; no clearing pass.
// out_stall_i holds the chain and the presented word.
`timescale 1ns / 1ps
`include "sort_and_count_inversions_unit_assert.svh"

module sort_and_count_inversions_unit import scic_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic signed [ValW-1:0] value_i,
  input  logic                   last_in_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [ValW-1:0] sorted_value_o,
  output logic [InvW-1:0]        inversions_o,
  output logic                   dropped_o,
  output logic                   last_out_o
);

  localparam int unsigned CntW = $clog2(DEPTH);
  localparam int unsigned SumW = ((CntW > InvW) ? CntW : InvW) + 1;

  st_e                    state_q, state_d;
  logic                   ovf_q, ovf_d;
  logic [InvW-1:0]        acc_q, acc_d;
  cell_ctrl_t             ctrl;
  logic                   accept_in;
  logic                   full;
  logic [SumW-1:0]        sum;
  logic [InvW-1:0]        sum_sat;

  logic                   gt  [DEPTH];
  logic                   vld [DEPTH];
  logic signed [ValW-1:0] val [DEPTH];
  logic [CntW-1:0]        cnt [DEPTH];

  assign full      = vld[DEPTH-1];
  assign accept_in = in_valid_i && !in_stall_o;

  // Broadcast control to the chain
  assign ctrl.ins = accept_in && !full;
  assign ctrl.shd = out_valid_o && !out_stall_i;
  assign ctrl.val = value_i;

  // Build the chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                   p_gt, p_vld, n_vld;
    logic signed [ValW-1:0] p_val, n_val;
    logic [CntW-1:0]        p_cnt, n_cnt;

    if (i == 0) begin : g_head
      assign p_gt  = 1'b0;
      assign p_vld = 1'b1;
      assign p_val = '0;
      assign p_cnt = '0;
    end else begin : g_link
      assign p_gt  = gt[i-1];
      assign p_vld = vld[i-1];
      assign p_val = val[i-1];
      assign p_cnt = cnt[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign n_vld = 1'b0;
      assign n_val = '0;
      assign n_cnt = '0;
    end else begin : g_next
      assign n_vld = vld[i+1];
      assign n_val = val[i+1];
      assign n_cnt = cnt[i+1];
    end

    scic_cell #(
      .CntW (CntW)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .prv_gt_i  (p_gt),
      .prv_vld_i (p_vld),
      .prv_val_i (p_val),
      .prv_cnt_i (p_cnt),
      .nxt_vld_i (n_vld),
      .nxt_val_i (n_val),
      .nxt_cnt_i (n_cnt),
      .gt_o      (gt[i]),
      .vld_o     (vld[i]),
      .val_o     (val[i]),
      .cnt_o     (cnt[i])
    );
  end

  // Saturating running total of the counts that have left the chain
  assign sum     = SumW'(acc_q) + SumW'(cnt[0]);
  assign sum_sat = (sum > SumW'(InvMax)) ? InvMax : sum[InvW-1:0];

  // Next phase
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_FILL: begin
        if (accept_in && last_in_i) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (ctrl.shd && last_out_o) state_d = ST_FILL;
      end
      default: state_d = ST_FILL;
    endcase
  end

  // Handshake and result word
  always_comb begin
    in_stall_o     = 1'b0;
    out_valid_o    = 1'b0;
    last_out_o     = 1'b0;
    unique case (state_q)
      ST_FILL: begin
        in_stall_o = 1'b0;
      end
      ST_DRAIN: begin
        in_stall_o  = 1'b1;
        out_valid_o = vld[0];
        last_out_o  = !vld[1];
      end
      default: in_stall_o = 1'b1;
    endcase
  end

  assign sorted_value_o = val[0];
  assign inversions_o   = last_out_o ? sum_sat : '0;
  assign dropped_o      = ovf_q;

  // Track drops and the total; clear both when the run ends
  always_comb begin
    ovf_d = ovf_q;
    acc_d = acc_q;
    if (accept_in && full) ovf_d = 1'b1;
    if (ctrl.shd) begin
      acc_d = sum_sat;
      if (last_out_o) begin
        ovf_d = 1'b0;
        acc_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_FILL;
      ovf_q   <= 1'b0;
      acc_q   <= '0;
    end else begin
      state_q <= state_d;
      ovf_q   <= ovf_d;
      acc_q   <= acc_d;
    end
  end

  `SCIC_ASSERT_IMPL(a_no_overlap, out_valid_o, in_stall_o, "word offered while input open")
  `SCIC_ASSERT_NEXT(a_insert_holds, ctrl.ins, vld[0], "chain empty after insert")
  `SCIC_ASSERT_NEXT(a_run_ends, ctrl.shd && last_out_o, !out_valid_o, "word after run end")
  `SCIC_ASSERT_NEXT(a_drop_flag, accept_in && full, dropped_o, "drop not flagged")

endmodule

/* src/scic_cell.sv */
// One cell of the insertion chain: holds a word and its greater-arrival count
`timescale 1ns / 1ps

module scic_cell import scic_pkg::*; #(
  parameter int unsigned CntW = 6
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cell_ctrl_t             ctrl_i,
  // neighbour towards cell 0
  input  logic                   prv_gt_i,
  input  logic                   prv_vld_i,
  input  logic signed [ValW-1:0] prv_val_i,
  input  logic [CntW-1:0]        prv_cnt_i,
  // neighbour away from cell 0
  input  logic                   nxt_vld_i,
  input  logic signed [ValW-1:0] nxt_val_i,
  input  logic [CntW-1:0]        nxt_cnt_i,
  // own contents
  output logic                   gt_o,
  output logic                   vld_o,
  output logic signed [ValW-1:0] val_o,
  output logic [CntW-1:0]        cnt_o
);

  logic                   vld_q, vld_d;
  logic signed [ValW-1:0] val_q, val_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   gt;

  // An empty cell counts as greater than any word
  assign gt = !vld_q || (val_q > ctrl_i.val);

  // Keep, shift up on insert, take the new word, or shift down on drain
  always_comb begin
    vld_d = vld_q;
    val_d = val_q;
    cnt_d = cnt_q;
    if (ctrl_i.shd) begin
      vld_d = nxt_vld_i;
      val_d = nxt_val_i;
      cnt_d = nxt_cnt_i;
    end else if (ctrl_i.ins && gt) begin
      if (prv_gt_i) begin
        // the moved word was greater than the new one: one more inversion
        vld_d = prv_vld_i;
        val_d = prv_val_i;
        cnt_d = prv_cnt_i + CntW'(1);
      end else begin
        vld_d = 1'b1;
        val_d = ctrl_i.val;
        cnt_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    cnt_q <= cnt_d;
  end

  assign gt_o  = gt;
  assign vld_o = vld_q;
  assign val_o = val_q;
  assign cnt_o = cnt_q;

endmodule
